/* rtl/core/ccint_pkg.sv */
// ----------------------------------------------------------------------------
// ccint_pkg
// Shared types and constants for the circle-circle intersection pipeline.
// ----------------------------------------------------------------------------
package ccint_pkg;

   typedef enum logic [1:0] {
      COUNT_NONE = 2'd0,
      COUNT_ONE  = 2'd1,
      COUNT_TWO  = 2'd2
   } count_type;

   localparam int LANE_COUNT = 4;
   localparam int LANE_AX    = 0;
   localparam int LANE_AY    = 1;
   localparam int LANE_BX    = 2;
   localparam int LANE_BY    = 3;

endpackage

/* rtl/core/circle_circle_intersection.sv */
// ----------------------------------------------------------------------------
// circle_circle_intersection
// Intersection of two integer circles: point count and points in fixed point.
// ----------------------------------------------------------------------------
// A request carries two circles (center and radius each) on the req_ channel
// with a valid/ready handshake. The response on the rsp_ channel gives the
// number of common points (0, 1 or 2) and the points in signed fixed point
// with FRAC_BITS fraction bits; unused points read as zero.
// From request to response the pipeline has four front stages, the input
// register and one stage per root bit of the square root, three numerator
// stages, the load stage and one stage per quotient bit of the four-lane
// divider and the output register.
// Throughput is one request per cycle while the pipeline is not held: every
// stage is a register with a valid bit and a new request may enter each cycle.
// When rsp_ready is low with a response pending, the whole pipeline holds
// and req_ready drops; nothing is lost or repeated. Reset clears all valid
// bits; the block takes requests from the first cycle after reset.
// ----------------------------------------------------------------------------
module circle_circle_intersection import ccint_pkg::*; #(
   parameter int COORD_WIDTH = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [COORD_WIDTH-1:0]         req_center_a_x,
   input  logic signed [COORD_WIDTH-1:0]         req_center_a_y,
   input  logic [COORD_WIDTH-2:0]                req_radius_a,
   input  logic signed [COORD_WIDTH-1:0]         req_center_b_x,
   input  logic signed [COORD_WIDTH-1:0]         req_center_b_y,
   input  logic [COORD_WIDTH-2:0]                req_radius_b,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_point_count,
   output logic signed [COORD_WIDTH+FRAC_BITS:0] rsp_point_a_x,
   output logic signed [COORD_WIDTH+FRAC_BITS:0] rsp_point_a_y,
   output logic signed [COORD_WIDTH+FRAC_BITS:0] rsp_point_b_x,
   output logic signed [COORD_WIDTH+FRAC_BITS:0] rsp_point_b_y
);

   localparam int W     = COORD_WIDTH;
   localparam int F     = FRAC_BITS;
   localparam int TW    = 2*W+3;
   localparam int D2W   = 2*W+2;
   localparam int KW    = 4*W;
   localparam int RT_W  = KW/2 + F;
   localparam int PTW   = TW - 1 + W + 1;
   localparam int PSW   = RT_W + W + 1;
   localparam int NW    = ((PTW+F > PSW) ? PTW+F : PSW) + 1;
   localparam int QW    = W + F;
   localparam int OW    = W + F + 1;
   localparam int SQ_SW = 2 + 2*W + TW + 2*(W+1) + D2W;
   localparam int PT_SW = 2 + 2*W;

   logic rsp_valid_ff;
   logic pipe_en;
   assign pipe_en   = !rsp_valid_ff || rsp_ready;
   assign req_ready = pipe_en && !reset;

   // front
   logic                 f_valid;
   count_type            f_count;
   logic signed [W-1:0]  f_ax, f_ay;
   logic signed [TW-1:0] f_t;
   logic signed [W:0]    f_dx, f_dy;
   logic [D2W-1:0]       f_d2;
   logic [KW-1:0]        f_k;

   ccint_front #(.COORD_W(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_valid),
      .ax        (req_center_a_x),
      .ay        (req_center_a_y),
      .ra        (req_radius_a),
      .bx        (req_center_b_x),
      .by        (req_center_b_y),
      .rb        (req_radius_b),
      .out_valid (f_valid),
      .out_count (f_count),
      .out_ax    (f_ax),
      .out_ay    (f_ay),
      .out_t     (f_t),
      .out_dx    (f_dx),
      .out_dy    (f_dy),
      .out_d2    (f_d2),
      .out_k     (f_k)
   );

   // square root
   logic [SQ_SW-1:0]     sq_side_in, sq_side_out;
   logic                 s_valid;
   logic [RT_W-1:0]      s_root;
   logic [1:0]           s_count;
   logic signed [W-1:0]  s_ax, s_ay;
   logic signed [TW-1:0] s_t;
   logic signed [W:0]    s_dx, s_dy;
   logic [D2W-1:0]       s_d2;

   assign sq_side_in = {f_count, f_ax, f_ay, f_t, f_dx, f_dy, f_d2};
   assign {s_count, s_ax, s_ay, s_t, s_dx, s_dy, s_d2} = sq_side_out;

   ccint_sqrt #(.IN_W(KW), .FRAC_W(F), .SIDE_W(SQ_SW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (f_valid),
      .radicand  (f_k),
      .side_in   (sq_side_in),
      .out_valid (s_valid),
      .root      (s_root),
      .side_out  (sq_side_out)
   );

   // numerators
   logic                          n_valid;
   logic [LANE_COUNT-1:0][NW-1:0] n_mag;
   logic [LANE_COUNT-1:0]         n_neg;
   logic [D2W-1:0]                n_d2;
   logic [PT_SW-1:0]              n_side;

   ccint_num #(.COORD_W(W), .FRAC_W(F), .ROOT_W(RT_W), .SIDE_W(PT_SW)) u_num (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (s_valid),
      .t         (s_t),
      .dx        (s_dx),
      .dy        (s_dy),
      .root      (s_root),
      .d2        (s_d2),
      .side_in   ({s_count, s_ax, s_ay}),
      .out_valid (n_valid),
      .num_mag   (n_mag),
      .num_neg   (n_neg),
      .d2_out    (n_d2),
      .side_out  (n_side)
   );

   // division
   logic                          q_valid;
   logic [LANE_COUNT-1:0][QW-1:0] q_val;
   logic [LANE_COUNT-1:0]         q_neg;
   logic [PT_SW-1:0]              q_side;
   logic [1:0]                    q_count_bits;
   count_type                     q_count;
   logic signed [W-1:0]           q_ax, q_ay;

   ccint_div #(.NUM_W(NW), .D2_W(D2W), .QUO_W(QW), .SIDE_W(PT_SW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (n_valid),
      .num_mag   (n_mag),
      .num_neg   (n_neg),
      .d2        (n_d2),
      .side_in   (n_side),
      .out_valid (q_valid),
      .quo       (q_val),
      .quo_neg   (q_neg),
      .side_out  (q_side)
   );

   assign {q_count_bits, q_ax, q_ay} = q_side;
   assign q_count = count_type'(q_count_bits);

   // final add onto the center and output register
   logic [OW-1:0] base_x, base_y;
   logic [OW-1:0] pt_in [LANE_COUNT];

   assign base_x = {q_ax[W-1], q_ax, {F{1'b0}}};
   assign base_y = {q_ay[W-1], q_ay, {F{1'b0}}};

   for (genvar l = 0; l < LANE_COUNT; l++) begin : g_pt
      logic [OW-1:0] base, qx;
      assign base     = (l == LANE_AX || l == LANE_BX) ? base_x : base_y;
      assign qx       = {{(OW-QW){1'b0}}, q_val[l]};
      assign pt_in[l] = q_neg[l] ? base - qx : base + qx;
   end

   logic [1:0]    count_ff;
   logic [OW-1:0] pax_ff, pay_ff, pbx_ff, pby_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= q_valid;
         count_ff     <= q_count;
         pax_ff       <= (q_count == COUNT_NONE) ? '0 : pt_in[LANE_AX];
         pay_ff       <= (q_count == COUNT_NONE) ? '0 : pt_in[LANE_AY];
         pbx_ff       <= (q_count == COUNT_TWO) ? pt_in[LANE_BX] : '0;
         pby_ff       <= (q_count == COUNT_TWO) ? pt_in[LANE_BY] : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_count = count_ff;
   assign rsp_point_a_x   = $signed(pax_ff);
   assign rsp_point_a_y   = $signed(pay_ff);
   assign rsp_point_b_x   = $signed(pbx_ff);
   assign rsp_point_b_y   = $signed(pby_ff);

endmodule

/* rtl/core/ccint_front.sv */
// ----------------------------------------------------------------------------
// ccint_front
// Front stages: center deltas, squared distance and radius bounds, exact
// point count, radical-line term t and the product k fed to the root.
// ----------------------------------------------------------------------------
module ccint_front import ccint_pkg::*; #(
   parameter int COORD_W = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic signed [COORD_W-1:0] ax,
   input  logic signed [COORD_W-1:0] ay,
   input  logic [COORD_W-2:0]        ra,
   input  logic signed [COORD_W-1:0] bx,
   input  logic signed [COORD_W-1:0] by,
   input  logic [COORD_W-2:0]        rb,
   output logic                      out_valid,
   output count_type                 out_count,
   output logic signed [COORD_W-1:0] out_ax,
   output logic signed [COORD_W-1:0] out_ay,
   output logic signed [2*COORD_W+2:0] out_t,
   output logic signed [COORD_W:0]   out_dx,
   output logic signed [COORD_W:0]   out_dy,
   output logic [2*COORD_W+1:0]      out_d2,
   output logic [4*COORD_W-1:0]      out_k
);

   localparam int W   = COORD_W;
   localparam int D2W = 2*W+2;
   localparam int TW  = 2*W+3;

   // stage 1
   logic                v1_ff;
   logic signed [W-1:0] ax1_ff, ay1_ff;
   logic [W-2:0]        ra1_ff, rb1_ff;
   logic signed [W:0]   dx1_ff, dy1_ff, dx1_in, dy1_in;

   assign dx1_in = (W+1)'(bx) - (W+1)'(ax);
   assign dy1_in = (W+1)'(by) - (W+1)'(ay);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff  <= in_valid;
         ax1_ff <= ax;
         ay1_ff <= ay;
         ra1_ff <= ra;
         rb1_ff <= rb;
         dx1_ff <= dx1_in;
         dy1_ff <= dy1_in;
      end
   end

   // stage 2
   logic signed [2*W+1:0] sqx, sqy;
   logic [W-1:0]          rsum;
   logic signed [W-1:0]   rdiff;
   logic signed [2*W-1:0] f2s;

   assign sqx   = dx1_ff * dx1_ff;
   assign sqy   = dy1_ff * dy1_ff;
   assign rsum  = {1'b0, ra1_ff} + {1'b0, rb1_ff};
   assign rdiff = $signed({1'b0, ra1_ff}) - $signed({1'b0, rb1_ff});
   assign f2s   = rdiff * rdiff;

   logic                v2_ff;
   logic signed [W-1:0] ax2_ff, ay2_ff;
   logic signed [W:0]   dx2_ff, dy2_ff;
   logic [D2W-1:0]      d22_ff;
   logic [2*W-1:0]      s22_ff, f22_ff;
   logic [2*W-3:0]      sqa2_ff, sqb2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff   <= v1_ff;
         ax2_ff  <= ax1_ff;
         ay2_ff  <= ay1_ff;
         dx2_ff  <= dx1_ff;
         dy2_ff  <= dy1_ff;
         d22_ff  <= $unsigned(sqx) + $unsigned(sqy);
         s22_ff  <= rsum * rsum;
         f22_ff  <= $unsigned(f2s);
         sqa2_ff <= ra1_ff * ra1_ff;
         sqb2_ff <= rb1_ff * rb1_ff;
      end
   end

   // stage 3
   logic [D2W-1:0]       s2x, f2x, diffa, diffb;
   count_type            count_in;
   logic signed [TW-1:0] t3_in;
   logic [2*W-1:0]       ka_in, kb_in;

   assign s2x   = {2'b00, s22_ff};
   assign f2x   = {2'b00, f22_ff};
   assign diffa = s2x - d22_ff;
   assign diffb = d22_ff - f2x;
   assign t3_in = $signed({5'b0, sqa2_ff}) - $signed({5'b0, sqb2_ff})
                + $signed({1'b0, d22_ff});

   always_comb begin
      if (d22_ff == '0 || d22_ff > s2x || d22_ff < f2x) begin
         count_in = COUNT_NONE;
      end else if (d22_ff == s2x || d22_ff == f2x) begin
         count_in = COUNT_ONE;
      end else begin
         count_in = COUNT_TWO;
      end
      ka_in = (count_in == COUNT_NONE) ? '0 : diffa[2*W-1:0];
      kb_in = (count_in == COUNT_NONE) ? '0 : diffb[2*W-1:0];
   end

   logic                 v3_ff;
   count_type            cnt3_ff;
   logic signed [W-1:0]  ax3_ff, ay3_ff;
   logic signed [W:0]    dx3_ff, dy3_ff;
   logic [D2W-1:0]       d23_ff;
   logic signed [TW-1:0] t3_ff;
   logic [2*W-1:0]       ka3_ff, kb3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff   <= v2_ff;
         cnt3_ff <= count_in;
         ax3_ff  <= ax2_ff;
         ay3_ff  <= ay2_ff;
         dx3_ff  <= dx2_ff;
         dy3_ff  <= dy2_ff;
         d23_ff  <= d22_ff;
         t3_ff   <= t3_in;
         ka3_ff  <= ka_in;
         kb3_ff  <= kb_in;
      end
   end

   // stage 4
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (en) begin
         out_valid <= v3_ff;
         out_count <= cnt3_ff;
         out_ax    <= ax3_ff;
         out_ay    <= ay3_ff;
         out_dx    <= dx3_ff;
         out_dy    <= dy3_ff;
         out_d2    <= d23_ff;
         out_t     <= t3_ff;
         out_k     <= ka3_ff * kb3_ff;
      end
   end

endmodule

/* rtl/core/ccint_sqrt.sv */
// ----------------------------------------------------------------------------
// ccint_sqrt
// Pipelined integer square root, one result bit per stage, of the input
// extended by 2*FRAC_W zero bits; a side word travels alongside.
// ----------------------------------------------------------------------------
module ccint_sqrt #(
   parameter int IN_W   = 64,
   parameter int FRAC_W = 16,
   parameter int SIDE_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [IN_W-1:0]            radicand,
   input  logic [SIDE_W-1:0]          side_in,
   output logic                       out_valid,
   output logic [(IN_W/2+FRAC_W)-1:0] root,
   output logic [SIDE_W-1:0]          side_out
);

   localparam int RAD_W = IN_W + 2*FRAC_W;
   localparam int RT_W  = RAD_W / 2;
   localparam int REM_W = RT_W + 3;

   logic              vld_ff  [0:RT_W];
   logic [RAD_W-1:0]  rad_ff  [0:RT_W];
   logic [REM_W-1:0]  rem_ff  [0:RT_W];
   logic [RT_W-1:0]   root_ff [0:RT_W];
   logic [SIDE_W-1:0] side_ff [0:RT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0]  <= in_valid;
         rad_ff[0]  <= {radicand, {(2*FRAC_W){1'b0}}};
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         side_ff[0] <= side_in;
      end
   end

   for (genvar i = 0; i < RT_W; i++) begin : g_step
      logic [REM_W-1:0] rem_sh, trial;
      logic             ge;

      assign rem_sh = {rem_ff[i][REM_W-3:0], rad_ff[i][RAD_W-1 -: 2]};
      assign trial  = {1'b0, root_ff[i], 2'b01};
      assign ge     = rem_sh >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1]  <= vld_ff[i];
            rad_ff[i+1]  <= {rad_ff[i][RAD_W-3:0], 2'b00};
            rem_ff[i+1]  <= ge ? rem_sh - trial : rem_sh;
            root_ff[i+1] <= {root_ff[i][RT_W-2:0], ge};
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[RT_W];
   assign root      = root_ff[RT_W];
   assign side_out  = side_ff[RT_W];

endmodule

/* rtl/core/ccint_num.sv */
// ----------------------------------------------------------------------------
// ccint_num
// Builds the four signed offset numerators t*lin*2^F +/- S*cross and splits
// them into magnitude and sign for the dividers.
// ----------------------------------------------------------------------------
module ccint_num import ccint_pkg::*; #(
   parameter int COORD_W = 16,
   parameter int FRAC_W  = 16,
   parameter int ROOT_W  = 48,
   parameter int SIDE_W  = 34
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic signed [2*COORD_W+2:0]  t,
   input  logic signed [COORD_W:0]      dx,
   input  logic signed [COORD_W:0]      dy,
   input  logic [ROOT_W-1:0]            root,
   input  logic [2*COORD_W+1:0]         d2,
   input  logic [SIDE_W-1:0]            side_in,
   output logic                         out_valid,
   output logic [LANE_COUNT-1:0][((3*COORD_W+3+FRAC_W > ROOT_W+COORD_W+1) ?
                 3*COORD_W+3+FRAC_W : ROOT_W+COORD_W+1)+1-1:0] num_mag,
   output logic [LANE_COUNT-1:0]        num_neg,
   output logic [2*COORD_W+1:0]         d2_out,
   output logic [SIDE_W-1:0]            side_out
);

   localparam int W   = COORD_W;
   localparam int TW  = 2*W+3;
   localparam int D2W = 2*W+2;
   localparam int PTW = TW - 1 + W + 1;
   localparam int PSW = ROOT_W + W + 1;
   localparam int VW  = ((PTW+FRAC_W > PSW) ? PTW+FRAC_W : PSW) + 2;
   localparam int NW  = VW - 1;

   // stage 1: magnitudes and products
   logic signed [TW-1:0] t_neg;
   logic signed [W:0]    dx_neg, dy_neg;
   logic [TW-2:0]        abs_t;
   logic [W:0]           abs_dx, abs_dy;

   assign t_neg  = -t;
   assign dx_neg = -dx;
   assign dy_neg = -dy;
   assign abs_t  = t[TW-1] ? t_neg[TW-2:0] : t[TW-2:0];
   assign abs_dx = dx[W] ? $unsigned(dx_neg) : $unsigned(dx);
   assign abs_dy = dy[W] ? $unsigned(dy_neg) : $unsigned(dy);

   logic              v1_ff, st1_ff, sx1_ff, sy1_ff;
   logic [PTW-1:0]    mtx1_ff, mty1_ff;
   logic [PSW-1:0]    msx1_ff, msy1_ff;
   logic [D2W-1:0]    d21_ff;
   logic [SIDE_W-1:0] side1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff    <= in_valid;
         st1_ff   <= t[TW-1];
         sx1_ff   <= dx[W];
         sy1_ff   <= dy[W];
         mtx1_ff  <= abs_t * abs_dx;
         mty1_ff  <= abs_t * abs_dy;
         msx1_ff  <= root * abs_dx;
         msy1_ff  <= root * abs_dy;
         d21_ff   <= d2;
         side1_ff <= side_in;
      end
   end

   // stage 2: signed sums
   logic signed [VW-1:0] t1x_p, t1y_p, t1x, t1y, m2x, m2y;
   logic signed [VW-1:0] v2_in [LANE_COUNT];

   assign t1x_p = $signed({{(VW-PTW-FRAC_W){1'b0}}, mtx1_ff, {FRAC_W{1'b0}}});
   assign t1y_p = $signed({{(VW-PTW-FRAC_W){1'b0}}, mty1_ff, {FRAC_W{1'b0}}});
   assign t1x   = (st1_ff ^ sx1_ff) ? -t1x_p : t1x_p;
   assign t1y   = (st1_ff ^ sy1_ff) ? -t1y_p : t1y_p;
   assign m2x   = $signed({{(VW-PSW){1'b0}}, msx1_ff});
   assign m2y   = $signed({{(VW-PSW){1'b0}}, msy1_ff});

   always_comb begin
      v2_in[LANE_AX] = t1x + (sy1_ff ? m2y : -m2y);
      v2_in[LANE_BX] = t1x + (sy1_ff ? -m2y : m2y);
      v2_in[LANE_AY] = t1y + (sx1_ff ? -m2x : m2x);
      v2_in[LANE_BY] = t1y + (sx1_ff ? m2x : -m2x);
   end

   logic                 v2_ff;
   logic signed [VW-1:0] sum2_ff [LANE_COUNT];
   logic [D2W-1:0]       d22_ff;
   logic [SIDE_W-1:0]    side2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff    <= v1_ff;
         sum2_ff  <= v2_in;
         d22_ff   <= d21_ff;
         side2_ff <= side1_ff;
      end
   end

   // stage 3: magnitude and sign
   logic [LANE_COUNT-1:0][NW-1:0] mag_in;
   logic [LANE_COUNT-1:0]         neg_in;

   for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
      logic signed [VW-1:0] vneg;
      assign vneg      = -sum2_ff[l];
      assign neg_in[l] = sum2_ff[l][VW-1];
      assign mag_in[l] = neg_in[l] ? vneg[NW-1:0] : sum2_ff[l][NW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (en) begin
         out_valid <= v2_ff;
         num_mag   <= mag_in;
         num_neg   <= neg_in;
         d2_out    <= d22_ff;
         side_out  <= side2_ff;
      end
   end

endmodule

/* rtl/core/ccint_div.sv */
// ----------------------------------------------------------------------------
// ccint_div
// Four-lane pipelined restoring divider, one quotient bit per stage:
// q = floor((num + d2) / (2*d2)), rounding to nearest on the magnitude.
// ----------------------------------------------------------------------------
module ccint_div import ccint_pkg::*; #(
   parameter int NUM_W  = 69,
   parameter int D2_W   = 34,
   parameter int QUO_W  = 32,
   parameter int SIDE_W = 34
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic [LANE_COUNT-1:0][NUM_W-1:0] num_mag,
   input  logic [LANE_COUNT-1:0]           num_neg,
   input  logic [D2_W-1:0]                 d2,
   input  logic [SIDE_W-1:0]               side_in,
   output logic                            out_valid,
   output logic [LANE_COUNT-1:0][QUO_W-1:0] quo,
   output logic [LANE_COUNT-1:0]           quo_neg,
   output logic [SIDE_W-1:0]               side_out
);

   localparam int DEN_W = D2_W + 1;

   logic                  vld_ff  [0:QUO_W];
   logic [DEN_W-1:0]      den_ff  [0:QUO_W];
   logic [LANE_COUNT-1:0] neg_ff  [0:QUO_W];
   logic [SIDE_W-1:0]     side_ff [0:QUO_W];
   logic [DEN_W-1:0]      rem_ff  [0:QUO_W][LANE_COUNT];
   logic [QUO_W-1:0]      low_ff  [0:QUO_W][LANE_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0]  <= in_valid;
         den_ff[0]  <= {d2, 1'b0};
         neg_ff[0]  <= num_neg;
         side_ff[0] <= side_in;
      end
   end

   for (genvar l = 0; l < LANE_COUNT; l++) begin : g_load
      logic [NUM_W:0] biased;
      assign biased = (NUM_W+1)'(num_mag[l]) + (NUM_W+1)'(d2);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[0][l] <= biased[QUO_W +: DEN_W];
            low_ff[0][l] <= biased[QUO_W-1:0];
         end
      end
   end

   for (genvar i = 0; i < QUO_W; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1]  <= vld_ff[i];
            den_ff[i+1]  <= den_ff[i];
            neg_ff[i+1]  <= neg_ff[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
      for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
         logic [DEN_W:0] r2, diff;
         logic           ge;
         assign r2   = {rem_ff[i][l], low_ff[i][l][QUO_W-1]};
         assign diff = r2 - {1'b0, den_ff[i]};
         assign ge   = r2 >= {1'b0, den_ff[i]};
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i+1][l] <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
               low_ff[i+1][l] <= {low_ff[i][l][QUO_W-2:0], ge};
            end
         end
      end
   end

   for (genvar l = 0; l < LANE_COUNT; l++) begin : g_out
      assign quo[l] = low_ff[QUO_W][l];
   end

   assign out_valid = vld_ff[QUO_W];
   assign quo_neg   = neg_ff[QUO_W];
   assign side_out  = side_ff[QUO_W];

endmodule
